// ===== hdl/slipcrc_pkg.sv =====
// Shared constants, result word type and CRC-16 byte update for the SLIP receiver.
package slipcrc_pkg;

   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'h0000;

   localparam int MIN_FRAME_BYTES = 8;
   localparam int LEN_WIDTH       = 11;
   localparam int STATUS_WIDTH    = 3;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] ST_OK  = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_LEN = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_CRC = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_ESC = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_OVF = 3'd4;

   typedef struct packed {
      logic                    out_kind;
      logic [7:0]              out_byte;
      logic [STATUS_WIDTH-1:0] frame_status;
      logic [LEN_WIDTH-1:0]    payload_length;
   } rsp_word_type;

   // CRC-16, MSB first, one byte per call
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== hdl/slipcrc_req_if.sv =====
// Input channel: one raw SLIP byte per word with valid/ready handshake.
interface slipcrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/slipcrc_rsp_if.sv =====
// Result channel: decoded payload bytes and frame verdicts with valid/ready handshake.
interface slipcrc_rsp_if import slipcrc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    out_kind;
   logic [7:0]              out_byte;
   logic [STATUS_WIDTH-1:0] frame_status;
   logic [LEN_WIDTH-1:0]    payload_length;

   modport source (output valid, output out_kind, output out_byte, output frame_status,
                   output payload_length, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input frame_status,
                   input payload_length, output ready);
endinterface

// ===== hdl/slip_frame_receiver_crc_check_core.sv =====
// SLIP frame receiver with CRC-16 check: deframer, unescaper, CRC engine and result buffer.
// An accepted byte's result (if any) is registered in rsp_ff, or in skid_ff if stalled.
// Throughput: one raw byte per cycle while ready is high; byte decode and the eight-bit
// CRC update are combinational between frame state registers and a two-word result buffer.
// req_if.ready drops only while both result buffer slots are full.
// Reset (synchronous, active high): wait for END, empty buffer, crc_hi_first_ff = 1.
module slip_frame_receiver_crc_check_core import slipcrc_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   slipcrc_req_if.sink          req_if,
   slipcrc_rsp_if.source        rsp_if,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data
);

   // byte counter must hold MAX_FRAME_BYTES itself
   localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

   // configuration
   logic              crc_hi_first_ff;

   // frame state
   logic              in_frame_ff,   in_frame_in;
   logic              esc_pend_ff,   esc_pend_in;
   logic [CW-1:0]     byte_count_ff, byte_count_in;
   logic [15:0]       crc_ff,        crc_in;
   logic [7:0]        held0_ff,      held0_in;   // older held byte
   logic [7:0]        held1_ff,      held1_in;
   logic [15:0]       len_ff,        len_in;

   // result buffer: output register plus skid slot
   rsp_word_type      rsp_ff,        rsp_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   rsp_word_type      skid_ff,       skid_in;
   logic              skid_valid_ff, skid_valid_in;

   logic              accept;
   logic              take;
   logic              push;
   rsp_word_type      new_word;
   logic [7:0]        rx;
   logic [7:0]        dec_byte;
   logic              have_byte;
   logic [CW-1:0]     emit_cnt;
   logic [15:0]       rx_crc;

   assign rx     = req_if.rx_byte;
   assign accept = req_if.valid && req_if.ready;
   assign take   = rsp_valid_ff && rsp_if.ready;

   // accept whenever the skid slot is free
   assign req_if.ready = !skid_valid_ff;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.out_kind       = rsp_ff.out_kind;
   assign rsp_if.out_byte       = rsp_ff.out_byte;
   assign rsp_if.frame_status   = rsp_ff.frame_status;
   assign rsp_if.payload_length = rsp_ff.payload_length;

   // payload bytes already passed out: the two newest decoded bytes are held back
   assign emit_cnt = (byte_count_ff >= CW'(2)) ? byte_count_ff - CW'(2) : '0;

   // received CRC in the configured byte order
   assign rx_crc = crc_hi_first_ff ? {held0_ff, held1_ff} : {held1_ff, held0_ff};

   // ---------------------------------------------------------------------------------------
   // Per-byte decode and frame state update
   // ---------------------------------------------------------------------------------------
   always_comb begin
      in_frame_in   = in_frame_ff;
      esc_pend_in   = esc_pend_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      len_in        = len_ff;
      push          = 1'b0;
      have_byte     = 1'b0;
      dec_byte      = rx;
      new_word      = '0;

      if (accept) begin
         if (rx == SLIP_END) begin
            // close the current frame (if it holds any byte) and open the next
            if (in_frame_ff && (byte_count_ff != '0)) begin
               push                    = 1'b1;
               new_word.out_kind       = KIND_VERDICT;
               new_word.payload_length = LEN_WIDTH'(emit_cnt);
               if ((byte_count_ff < CW'(MIN_FRAME_BYTES)) ||
                   (len_ff != 16'(byte_count_ff))) begin
                  new_word.frame_status = ST_LEN;
               end else if (rx_crc != crc_ff) begin
                  new_word.frame_status = ST_CRC;
               end else begin
                  new_word.frame_status = ST_OK;
               end
            end
            in_frame_in   = 1'b1;
            esc_pend_in   = 1'b0;
            byte_count_in = '0;
            crc_in        = CRC_INIT;
            held0_in      = 8'h00;
            held1_in      = 8'h00;
            len_in        = 16'h0000;
         end else if (in_frame_ff) begin
            if (esc_pend_ff) begin
               esc_pend_in = 1'b0;
               if (rx == SLIP_ESC_END) begin
                  dec_byte  = SLIP_END;
                  have_byte = 1'b1;
               end else if (rx == SLIP_ESC_ESC) begin
                  dec_byte  = SLIP_ESC;
                  have_byte = 1'b1;
               end else begin
                  // bad escape: abort and resync on next END
                  push                    = 1'b1;
                  new_word.out_kind       = KIND_VERDICT;
                  new_word.frame_status   = ST_ESC;
                  new_word.payload_length = LEN_WIDTH'(emit_cnt);
                  in_frame_in             = 1'b0;
                  byte_count_in           = '0;
               end
            end else if (rx == SLIP_ESC) begin
               esc_pend_in = 1'b1;
            end else begin
               have_byte = 1'b1;
            end

            if (have_byte) begin
               if (byte_count_ff >= CW'(MAX_FRAME_BYTES)) begin
                  // overflow: drop the byte, abort and resync
                  push                    = 1'b1;
                  new_word.out_kind       = KIND_VERDICT;
                  new_word.frame_status   = ST_OVF;
                  new_word.payload_length = LEN_WIDTH'(emit_cnt);
                  in_frame_in             = 1'b0;
                  esc_pend_in             = 1'b0;
                  byte_count_in           = '0;
               end else begin
                  // capture the big-endian length field from bytes 4 and 5
                  if (byte_count_ff == CW'(4)) begin
                     len_in = {dec_byte, 8'h00};
                  end else if (byte_count_ff == CW'(5)) begin
                     len_in = {len_ff[15:8], dec_byte};
                  end

                  if (byte_count_ff >= CW'(2)) begin
                     // release the oldest held byte as payload
                     push              = 1'b1;
                     new_word.out_kind = KIND_DATA;
                     new_word.out_byte = held0_ff;
                     crc_in            = crc16_update(crc_ff, held0_ff);
                     held0_in          = held1_ff;
                     held1_in          = dec_byte;
                  end else if (byte_count_ff[0]) begin
                     held1_in = dec_byte;
                  end else begin
                     held0_in = dec_byte;
                  end
                  byte_count_in = byte_count_ff + CW'(1);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result buffer: output register with a skid slot behind it
   // ---------------------------------------------------------------------------------------
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;

      if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            // advance the skid word; ready was low so nothing new arrives
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = new_word;
            rsp_valid_in = push;
         end
      end else if (push) begin
         // hold the output word, park the new one
         skid_in       = new_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_hi_first_ff <= 1'b1;
         in_frame_ff     <= 1'b0;
         esc_pend_ff     <= 1'b0;
         byte_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            crc_hi_first_ff <= csr_wr_data;
         end
         in_frame_ff   <= in_frame_in;
         esc_pend_ff   <= esc_pend_in;
         byte_count_ff <= byte_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // crc_ff, held and len_ff: always rewritten by the END that opens a frame before first use
   always_ff @(posedge clock) begin
      crc_ff   <= crc_in;
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      len_ff   <= len_in;
      rsp_ff   <= rsp_in;
      skid_ff  <= skid_in;
   end

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot full while output register empty");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid_ff)
      else $error("result produced but not presented");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CW'(MAX_FRAME_BYTES))
      else $error("byte count beyond frame limit");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (byte_count_ff == '0) && !esc_pend_ff)
      else $error("frame state left over while waiting for END");

endmodule
